>>> sv/assert_macros.svh
// Assertion helpers, used by the packet serialiser RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// An implication checked at every clock edge outside reset.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

>>> sv/dcrsf_pkg.sv
`timescale 1ns / 1ps

package dcrsf_pkg;

  // Filter sizes.
  localparam int DC_SHIFT_BITS = 14;
  localparam int SAMPLE_BITS   = 24;
  localparam int ACC_BITS      = 40;
  localparam int AC_BITS       = 24;

  // Configuration register indexes.
  localparam int CFG_INDEX_BITS = 2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ADC_RES     = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SAMPLE_RATE = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_VREF_HALF   = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BEAT_PERIOD = 2'd3;

  // Configuration reset values.
  localparam logic [7:0]  RST_ADC_RES     = 8'd20;
  localparam logic [15:0] RST_SAMPLE_RATE = 16'd0;
  localparam logic [15:0] RST_VREF_HALF   = 16'd6144;
  localparam logic [15:0] RST_BEAT_PERIOD = 16'd3000;
  localparam logic [7:0]  RST_REF_VALUE   = 8'h94;

  // Command bytes and argument limits.
  localparam logic [7:0] CMD_FULL_CONFIG = 8'hA5;
  localparam logic [7:0] CMD_SET_GAIN    = 8'hA6;
  localparam logic [7:0] CMD_SET_MUX     = 8'hA7;
  localparam logic [7:0] CMD_SET_VREF    = 8'hAA;
  localparam logic [7:0] GAIN_MAX        = 8'd8;
  localparam logic [7:0] CHAN_MAX        = 8'd2;

  // Packet framing.
  localparam logic [7:0] PKT_SYNC      = 8'h56;
  localparam logic [7:0] VSTAT_TRAILER = 8'h01;
  localparam logic [2:0] LAST_BYTE_IDX = 3'd4;

  // Packet slots in emission order; a job sends a contiguous run of them.
  localparam logic [2:0] PK_DATA  = 3'd0;
  localparam logic [2:0] PK_HB    = 3'd1;
  localparam logic [2:0] PK_CFG   = 3'd2;
  localparam logic [2:0] PK_GAIN  = 3'd3;
  localparam logic [2:0] PK_VSTAT = 3'd4;
  localparam logic [2:0] PK_VCFG  = 3'd5;
  localparam logic [2:0] PK_MUX   = 3'd6;

  // Type byte carried in the second byte of each packet.
  localparam logic [7:0] CODE_DATA  = 8'h00;
  localparam logic [7:0] CODE_HB    = 8'h01;
  localparam logic [7:0] CODE_CFG   = 8'h02;
  localparam logic [7:0] CODE_GAIN  = 8'h03;
  localparam logic [7:0] CODE_VSTAT = 8'h04;
  localparam logic [7:0] CODE_MUX   = 8'h05;
  localparam logic [7:0] CODE_VCFG  = 8'h06;

  typedef struct packed {
    logic              mode;
    logic [7:0]        command_byte;
    logic signed [23:0] adc_sample;
  } in_item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last_byte;
    logic [3:0] gain_setting;
    logic [1:0] mux_channel;
    logic [7:0] vref_positive;
    logic [7:0] vref_negative;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  adc_res;
    logic [15:0] sample_rate;
    logic [15:0] vref_half;
    logic [15:0] beat_period;
  } cfg_t;

  // One job: a run of packets plus the state snapshot they report.
  typedef struct packed {
    logic [2:0]         start_pkt;
    logic [2:0]         end_pkt;
    logic [AC_BITS-1:0] sample;
    logic [AC_BITS-1:0] est;
    logic [3:0]         gain;
    logic [1:0]         chan;
    logic [7:0]         ref_pos;
    logic [7:0]         ref_neg;
  } job_t;

  function automatic logic [7:0] pkt_code(input logic [2:0] pkt);
    logic [7:0] code;
    case (pkt)
      PK_DATA:  code = CODE_DATA;
      PK_HB:    code = CODE_HB;
      PK_CFG:   code = CODE_CFG;
      PK_GAIN:  code = CODE_GAIN;
      PK_VSTAT: code = CODE_VSTAT;
      PK_VCFG:  code = CODE_VCFG;
      PK_MUX:   code = CODE_MUX;
      default:  code = CODE_DATA;
    endcase
    return code;
  endfunction

endpackage

>>> sv/dcrsf_proc.sv
`timescale 1ns / 1ps

module dcrsf_proc import dcrsf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  in_item_t    item,
  input  logic [15:0] beat_period,
  input  logic        job_free,
  output logic        job_load,
  output job_t        job
);

  logic                       ir_valid;
  in_item_t                   ir;
  logic [ACC_BITS-1:0]        acc;
  logic [15:0]                beat_count;
  logic                       awaiting;
  logic [7:0]                 pending;
  logic                       arg_seen;
  logic [7:0]                 first_arg;
  logic [3:0]                 gain;
  logic [1:0]                 chan;
  logic [7:0]                 ref_pos;
  logic [7:0]                 ref_neg;

  logic [ACC_BITS-1:0]        acc_next;
  logic [15:0]                beat_count_next;
  logic                       awaiting_next;
  logic [7:0]                 pending_next;
  logic                       arg_seen_next;
  logic [7:0]                 first_arg_next;
  logic [3:0]                 gain_next;
  logic [1:0]                 chan_next;
  logic [7:0]                 ref_pos_next;
  logic [7:0]                 ref_neg_next;

  logic                       take;
  logic                       has_job;
  logic [2:0]                 start_pkt;
  logic [2:0]                 end_pkt;
  logic [ACC_BITS-1:0]        s_ext;
  logic [ACC_BITS-1:0]        est_old;
  logic [ACC_BITS-1:0]        acc_sum;
  logic [ACC_BITS-1:0]        est_new;
  logic [15:0]                hb_inc;
  logic [7:0]                 cmd;

  // The buffered item is processed as soon as the serialiser can take its job.
  assign take       = ir_valid && job_free;
  assign item_stall = ir_valid && !job_free;

  // Leaky integrator arithmetic for a sample item.
  assign s_ext   = {{(ACC_BITS-SAMPLE_BITS){ir.adc_sample[SAMPLE_BITS-1]}},
                    ir.adc_sample[SAMPLE_BITS-1:0]};
  assign est_old = ACC_BITS'($signed(acc) >>> DC_SHIFT_BITS);
  assign acc_sum = acc + s_ext - est_old;
  assign est_new = ACC_BITS'($signed(acc_sum) >>> DC_SHIFT_BITS);
  assign hb_inc  = beat_count + 16'd1;
  assign cmd     = ir.command_byte;

  // Next state and job selection for the buffered item.
  always_comb begin
    acc_next        = acc;
    beat_count_next = beat_count;
    awaiting_next   = awaiting;
    pending_next    = pending;
    arg_seen_next   = arg_seen;
    first_arg_next  = first_arg;
    gain_next       = gain;
    chan_next       = chan;
    ref_pos_next    = ref_pos;
    ref_neg_next    = ref_neg;
    has_job         = 1'b0;
    start_pkt       = PK_DATA;
    end_pkt         = PK_DATA;
    if (ir.mode) begin
      acc_next  = acc_sum;
      has_job   = 1'b1;
      if (hb_inc >= beat_period) begin
        beat_count_next = 16'd0;
        end_pkt         = PK_HB;
      end else begin
        beat_count_next = hb_inc;
      end
    end else if (!awaiting) begin
      if (cmd == CMD_FULL_CONFIG) begin
        has_job   = 1'b1;
        start_pkt = PK_CFG;
        end_pkt   = PK_MUX;
      end else if (cmd == CMD_SET_GAIN || cmd == CMD_SET_MUX || cmd == CMD_SET_VREF) begin
        pending_next  = cmd;
        arg_seen_next = 1'b0;
        awaiting_next = 1'b1;
      end
    end else begin
      case (pending)
        CMD_SET_GAIN: begin
          if (cmd <= GAIN_MAX) begin
            gain_next = cmd[3:0];
            has_job   = 1'b1;
            start_pkt = PK_CFG;
            end_pkt   = PK_MUX;
          end
          awaiting_next = 1'b0;
        end
        CMD_SET_MUX: begin
          if (cmd <= CHAN_MAX) begin
            chan_next = cmd[1:0];
            acc_next  = '0;
            has_job   = 1'b1;
            start_pkt = PK_MUX;
            end_pkt   = PK_MUX;
          end
          awaiting_next = 1'b0;
        end
        CMD_SET_VREF: begin
          if (!arg_seen) begin
            first_arg_next = cmd;
            arg_seen_next  = 1'b1;
          end else begin
            ref_pos_next  = first_arg;
            ref_neg_next  = cmd;
            has_job       = 1'b1;
            start_pkt     = PK_VSTAT;
            end_pkt       = PK_VCFG;
            awaiting_next = 1'b0;
          end
        end
        default: begin
          awaiting_next = 1'b0;
        end
      endcase
    end
  end

  // Job handed to the serialiser carries the state after this item.
  assign job_load      = take && has_job;
  assign job.start_pkt = start_pkt;
  assign job.end_pkt   = end_pkt;
  assign job.sample    = s_ext[AC_BITS-1:0];
  assign job.est       = est_new[AC_BITS-1:0];
  assign job.gain      = gain_next;
  assign job.chan      = chan_next;
  assign job.ref_pos   = ref_pos_next;
  assign job.ref_neg   = ref_neg_next;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      ir_valid <= 1'b1;
    end else if (take) begin
      ir_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      ir <= item;
    end
  end

  // Filter and parser state.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc        <= '0;
      beat_count <= 16'd0;
      awaiting   <= 1'b0;
      pending    <= 8'd0;
      arg_seen   <= 1'b0;
      gain       <= 4'd0;
      chan       <= 2'd0;
      ref_pos    <= RST_REF_VALUE;
      ref_neg    <= RST_REF_VALUE;
    end else if (take) begin
      acc        <= acc_next;
      beat_count <= beat_count_next;
      awaiting   <= awaiting_next;
      pending    <= pending_next;
      arg_seen   <= arg_seen_next;
      gain       <= gain_next;
      chan       <= chan_next;
      ref_pos    <= ref_pos_next;
      ref_neg    <= ref_neg_next;
    end
  end

  // The first reference argument is only read after it has been written.
  always_ff @(posedge clk) begin
    if (take) begin
      first_arg <= first_arg_next;
    end
  end

endmodule

>>> sv/dcrsf_tx.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dcrsf_tx import dcrsf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      job_load,
  input  job_t      job,
  output logic      job_free,
  output logic      result_valid,
  input  logic      result_stall,
  output out_item_t result
);

  logic               jv;
  job_t               jb;
  logic [2:0]         pkt;
  logic [2:0]         bidx;
  logic               ov;
  out_item_t          ob;

  logic               out_load;
  logic               job_last;
  logic [AC_BITS-1:0] ac;
  logic [7:0]         byte_val;

  // A byte moves to the output register whenever that register is free or being taken.
  assign out_load = jv && (!ov || !result_stall);
  assign job_last = (bidx == LAST_BYTE_IDX) && (pkt == jb.end_pkt);
  assign job_free = !jv || (out_load && job_last);

  // The AC value is the sample minus the updated estimate, wrapped to 24 bits.
  assign ac = jb.sample - jb.est;

  // Byte selection for the current packet and byte position.
  always_comb begin
    byte_val = 8'd0;
    case (bidx)
      3'd0: byte_val = PKT_SYNC;
      3'd1: byte_val = pkt_code(pkt);
      3'd2: begin
        case (pkt)
          PK_DATA:  byte_val = ac[23:16];
          PK_CFG:   byte_val = cfg.adc_res;
          PK_GAIN:  byte_val = {4'd0, jb.gain};
          PK_VSTAT: byte_val = jb.ref_pos;
          PK_VCFG:  byte_val = jb.ref_pos;
          PK_MUX:   byte_val = {6'd0, jb.chan};
          default:  byte_val = 8'd0;
        endcase
      end
      3'd3: begin
        case (pkt)
          PK_DATA:  byte_val = ac[15:8];
          PK_CFG:   byte_val = cfg.sample_rate[15:8];
          PK_GAIN:  byte_val = cfg.vref_half[15:8];
          PK_VSTAT: byte_val = jb.ref_neg;
          PK_VCFG:  byte_val = jb.ref_neg;
          default:  byte_val = 8'd0;
        endcase
      end
      3'd4: begin
        case (pkt)
          PK_DATA:  byte_val = ac[7:0];
          PK_CFG:   byte_val = cfg.sample_rate[7:0];
          PK_GAIN:  byte_val = cfg.vref_half[7:0];
          PK_VSTAT: byte_val = VSTAT_TRAILER;
          default:  byte_val = 8'd0;
        endcase
      end
      default: byte_val = 8'd0;
    endcase
  end

  // Job register and its packet and byte counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      jv   <= 1'b0;
      pkt  <= PK_DATA;
      bidx <= 3'd0;
    end else if (job_load) begin
      jv   <= 1'b1;
      pkt  <= job.start_pkt;
      bidx <= 3'd0;
    end else if (out_load) begin
      if (job_last) begin
        jv <= 1'b0;
      end else if (bidx == LAST_BYTE_IDX) begin
        bidx <= 3'd0;
        pkt  <= pkt + 3'd1;
      end else begin
        bidx <= bidx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_load) begin
      jb <= job;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else begin
      ov <= out_load || (ov && result_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      ob.tx_byte       <= byte_val;
      ob.last_byte     <= job_last;
      ob.gain_setting  <= jb.gain;
      ob.mux_channel   <= jb.chan;
      ob.vref_positive <= jb.ref_pos;
      ob.vref_negative <= jb.ref_neg;
    end
  end

  assign result_valid = ov;
  assign result       = ob;

  // Checks on the serialiser.
  `ASSERT_ALWAYS(a_bidx_range, clk, rst, !jv || (bidx <= LAST_BYTE_IDX))
  `ASSERT_ALWAYS(a_pkt_range, clk, rst, !jv || (pkt <= jb.end_pkt))
  `ASSERT_IMPLIES(a_load_when_free, clk, rst, job_load, job_free)
  `ASSERT_IMPLIES(a_more_bytes, clk, rst, ov && !result_stall && !ob.last_byte, jv)

endmodule

>>> sv/dc_removal_sample_framer_unit.sv
`timescale 1ns / 1ps
// DC removal sample framer.
// Input channel (item_valid, item_stall, item): each item is either a received
// command byte or a new ADC sample, chosen by its mode field. Results leave on
// (result_valid, result_stall, result) as one packet byte per item, with
// last_byte set on the final byte that an input causes. Transfers happen
// on an edge with valid high and stall low.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is
// always ready; write it only while the block is idle.
// The first byte of a result passes from the input register through the job
// register to the output register. Bytes then follow one per cycle unless the
// result channel stalls: a sample gives 5 or 10 bytes, a full configuration
// 25. The byte serialiser sets the rate: an item holds it until its last byte
// is sent, and an item with no result passes once the serialiser is free.
// A new input item is buffered while the previous one is still sending.
// A stall on the result channel holds the output byte and backs up through the
// serialiser to item_stall.
// Reset clears the integrator, heartbeat counter and parser, sets gain and mux
// to zero, both references to 0x94 and the registers to their defaults.

module dc_removal_sample_framer_unit import dcrsf_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      item_valid,
  output logic                      item_stall,
  input  in_item_t                  item,
  output logic                      result_valid,
  input  logic                      result_stall,
  output out_item_t                 result,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [15:0]               cfg_data
);

  cfg_t cfg;
  logic job_load;
  logic job_free;
  job_t job;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.adc_res     <= RST_ADC_RES;
      cfg.sample_rate <= RST_SAMPLE_RATE;
      cfg.vref_half   <= RST_VREF_HALF;
      cfg.beat_period <= RST_BEAT_PERIOD;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ADC_RES:     cfg.adc_res     <= cfg_data[7:0];
        REG_SAMPLE_RATE: cfg.sample_rate <= cfg_data;
        REG_VREF_HALF:   cfg.vref_half   <= cfg_data;
        REG_BEAT_PERIOD: cfg.beat_period <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Filter, heartbeat and command parser.
  dcrsf_proc u_proc (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .beat_period (cfg.beat_period),
    .job_free    (job_free),
    .job_load    (job_load),
    .job         (job)
  );

  // Packet serialiser and output register.
  dcrsf_tx u_tx (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .job_load     (job_load),
    .job          (job),
    .job_free     (job_free),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

>>> verif/dcrsf_stream_checker.sv
`timescale 1ns / 1ps

// Watches the item, result and register channels of the DC removal framer.
// It predicts the packet bytes that each accepted item causes and compares
// every result item, field by field, with the oldest byte still owed.
module dcrsf_stream_checker import dcrsf_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      item_valid,
  input  logic                      item_stall,
  input  in_item_t                  item,
  input  logic                      result_valid,
  input  logic                      result_stall,
  input  out_item_t                 result,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [15:0]               cfg_data,
  output int                        mismatch_count,
  output int                        bytes_owed
);

  // Shadow copy of the registers and of the block's state.
  cfg_t               regs;
  logic signed [39:0] dc_acc;
  logic [15:0]        beat_count;
  logic               awaiting_arg;
  logic [7:0]         pending_cmd;
  logic               have_first_arg;
  logic [7:0]         first_arg;
  logic [3:0]         gain;
  logic [1:0]         chan;
  logic [7:0]         ref_pos;
  logic [7:0]         ref_neg;

  // Bytes framed for the item in hand, and every byte still owed by the block.
  logic [7:0] frame_bytes[$];
  out_item_t  owed_bytes[$];
  int         errors = 0;

  function automatic void add_packet(input logic [7:0] code, input logic [7:0] b2,
                                     input logic [7:0] b3, input logic [7:0] b4);
    frame_bytes.push_back(PKT_SYNC);
    frame_bytes.push_back(code);
    frame_bytes.push_back(b2);
    frame_bytes.push_back(b3);
    frame_bytes.push_back(b4);
  endfunction

  function automatic void add_vref_packets();
    add_packet(CODE_VSTAT, ref_pos, ref_neg, VSTAT_TRAILER);
    add_packet(CODE_VCFG, ref_pos, ref_neg, 8'h00);
  endfunction

  function automatic void add_mux_packet();
    add_packet(CODE_MUX, {6'd0, chan}, 8'h00, 8'h00);
  endfunction

  function automatic void add_full_config();
    add_packet(CODE_CFG, regs.adc_res, regs.sample_rate[15:8], regs.sample_rate[7:0]);
    add_packet(CODE_GAIN, {4'd0, gain}, regs.vref_half[15:8], regs.vref_half[7:0]);
    add_vref_packets();
    add_mux_packet();
  endfunction

  // Works out the bytes that one accepted item causes and queues them.
  task automatic predict_packet_bytes(input in_item_t it);
    logic signed [39:0] smp;
    logic signed [39:0] est;
    logic [23:0]        ac;
    logic [7:0]         b;
    out_item_t          want;
    frame_bytes.delete();
    if (it.mode) begin
      // Leaky integrator, then the sample less the new estimate.
      smp = {{16{it.adc_sample[23]}}, it.adc_sample};
      dc_acc = dc_acc + smp - (dc_acc >>> DC_SHIFT_BITS);
      est = dc_acc >>> DC_SHIFT_BITS;
      ac = 24'(smp - est);
      add_packet(CODE_DATA, ac[23:16], ac[15:8], ac[7:0]);
      beat_count = beat_count + 16'd1;
      if (beat_count >= regs.beat_period) begin
        beat_count = '0;
        add_packet(CODE_HB, 8'h00, 8'h00, 8'h00);
      end
    end else begin
      b = it.command_byte;
      if (!awaiting_arg) begin
        if (b == CMD_FULL_CONFIG) begin
          add_full_config();
        end else if (b == CMD_SET_GAIN || b == CMD_SET_MUX || b == CMD_SET_VREF) begin
          pending_cmd = b;
          have_first_arg = 1'b0;
          awaiting_arg = 1'b1;
        end
      end else begin
        // An invalid argument is dropped and the parser goes back to idle.
        case (pending_cmd)
          CMD_SET_GAIN: begin
            if (b <= GAIN_MAX) begin
              gain = b[3:0];
              add_full_config();
            end
            awaiting_arg = 1'b0;
          end
          CMD_SET_MUX: begin
            if (b <= CHAN_MAX) begin
              chan = b[1:0];
              dc_acc = '0;
              add_mux_packet();
            end
            awaiting_arg = 1'b0;
          end
          CMD_SET_VREF: begin
            if (!have_first_arg) begin
              first_arg = b;
              have_first_arg = 1'b1;
            end else begin
              ref_pos = first_arg;
              ref_neg = b;
              add_vref_packets();
              awaiting_arg = 1'b0;
            end
          end
          default: awaiting_arg = 1'b0;
        endcase
      end
    end
    // Every byte reports the settings held once the item has been handled.
    for (int k = 0; k < frame_bytes.size(); k++) begin
      want.tx_byte       = frame_bytes[k];
      want.last_byte     = (k == frame_bytes.size() - 1);
      want.gain_setting  = gain;
      want.mux_channel   = chan;
      want.vref_positive = ref_pos;
      want.vref_negative = ref_neg;
      owed_bytes.push_back(want);
    end
  endtask

  function automatic void compare_field(input string field, input logic [7:0] want,
                                        input logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t ns: %s expected %02h, actual %02h", $time, field, want, got);
    end
  endfunction

  task automatic check_result_byte(input out_item_t got);
    out_item_t want;
    if (owed_bytes.size() == 0) begin
      errors++;
      $display("%0t ns: result byte expected none, actual %02h", $time, got.tx_byte);
    end else begin
      want = owed_bytes.pop_front();
      compare_field("tx_byte", want.tx_byte, got.tx_byte);
      compare_field("last_byte", {7'd0, want.last_byte}, {7'd0, got.last_byte});
      compare_field("gain_setting", {4'd0, want.gain_setting}, {4'd0, got.gain_setting});
      compare_field("mux_channel", {6'd0, want.mux_channel}, {6'd0, got.mux_channel});
      compare_field("vref_positive", want.vref_positive, got.vref_positive);
      compare_field("vref_negative", want.vref_negative, got.vref_negative);
    end
  endtask

  // All three channels are sampled at the rising edge.
  always @(posedge clk) begin
    if (rst) begin
      regs.adc_res     = RST_ADC_RES;
      regs.sample_rate = RST_SAMPLE_RATE;
      regs.vref_half   = RST_VREF_HALF;
      regs.beat_period = RST_BEAT_PERIOD;
      dc_acc           = '0;
      beat_count       = '0;
      awaiting_arg     = 1'b0;
      pending_cmd      = '0;
      have_first_arg   = 1'b0;
      first_arg        = '0;
      gain             = '0;
      chan             = '0;
      ref_pos          = RST_REF_VALUE;
      ref_neg          = RST_REF_VALUE;
      owed_bytes.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ADC_RES:     regs.adc_res = cfg_data[7:0];
          REG_SAMPLE_RATE: regs.sample_rate = cfg_data;
          REG_VREF_HALF:   regs.vref_half = cfg_data;
          REG_BEAT_PERIOD: regs.beat_period = cfg_data;
          default: ;
        endcase
      end
      if (item_valid && !item_stall)
        predict_packet_bytes(item);
      if (result_valid && !result_stall)
        check_result_byte(result);
    end
    mismatch_count <= errors;
    bytes_owed <= owed_bytes.size();
  end

endmodule

>>> verif/dc_removal_sample_framer_unit_test.sv
`timescale 1ns / 1ps

module dc_removal_sample_framer_unit_test;
  import dcrsf_pkg::*;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      item_valid = 1'b0;
  logic                      item_stall;
  in_item_t                  item = '0;
  logic                      result_valid;
  logic                      result_stall = 1'b0;
  out_item_t                 result;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [15:0]               cfg_data = '0;

  int         mismatch_count;
  int         bytes_owed;
  bit         sender_idles = 1'b1;
  bit         receiver_stalls = 1'b1;
  bit         hold_request = 1'b0;
  bit         hold_taken = 1'b0;
  logic [23:0] dc_bias = '0;

  always #5 clk = ~clk;

  dc_removal_sample_framer_unit dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  dcrsf_stream_checker checker_inst (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .item           (item),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .result         (result),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .bytes_owed     (bytes_owed)
  );

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request && !hold_taken) begin
        hold_taken = 1'b1;
        result_stall <= 1'b1;
        repeat (400) @(posedge clk);
      end
      result_stall <= receiver_stalls && ($urandom_range(99) < 24);
    end
  end

  // Offers one item and waits until it has been taken.
  task automatic send_item(input in_item_t it);
    while (sender_idles && $urandom_range(99) < 24) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
  endtask

  task automatic send_cmd(input logic [7:0] b);
    in_item_t it;
    it.mode = 1'b0;
    it.command_byte = b;
    it.adc_sample = 24'($urandom);
    send_item(it);
  endtask

  task automatic send_sample(input logic [23:0] s);
    in_item_t it;
    it.mode = 1'b1;
    it.command_byte = 8'($urandom);
    it.adc_sample = s;
    send_item(it);
  endtask

  // Lets the block drain completely before the registers are touched.
  task automatic wait_idle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (bytes_owed != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] res, input logic [15:0] rate,
                            input logic [15:0] vref, input logic [15:0] period);
    logic [CFG_INDEX_BITS-1:0] idx [4];
    logic [15:0]               val [4];
    idx = '{REG_ADC_RES, REG_SAMPLE_RATE, REG_VREF_HALF, REG_BEAT_PERIOD};
    val = '{{8'h00, res}, rate, vref, period};
    for (int i = 0; i < 4; i++) begin
      cfg_index <= idx[i];
      cfg_data <= val[i];
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [23:0] pick_sample();
    if ($urandom_range(1))
      return 24'($urandom);
    return dc_bias + 24'($urandom_range(511)) - 24'd256;
  endfunction

  // Mostly well-formed command sequences and samples, with some broken
  // sequences and stray bytes mixed in.
  task automatic send_random_traffic(input int n_items);
    int count;
    int pick;
    count = 0;
    while (count < n_items) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        send_sample(pick_sample());
        count += 1;
      end else if (pick < 53) begin
        send_cmd(CMD_FULL_CONFIG);
        count += 1;
      end else if (pick < 65) begin
        send_cmd(CMD_SET_GAIN);
        send_cmd(($urandom_range(9) < 8) ? 8'($urandom_range(8)) : 8'($urandom));
        count += 2;
      end else if (pick < 77) begin
        send_cmd(CMD_SET_MUX);
        send_cmd(($urandom_range(9) < 8) ? 8'($urandom_range(2)) : 8'($urandom));
        count += 2;
      end else if (pick < 90) begin
        send_cmd(CMD_SET_VREF);
        send_cmd(8'($urandom));
        send_cmd(8'($urandom));
        count += 3;
      end else if (pick < 95) begin
        // A command opener left without its arguments.
        case ($urandom_range(2))
          0: send_cmd(CMD_SET_GAIN);
          1: send_cmd(CMD_SET_MUX);
          default: send_cmd(CMD_SET_VREF);
        endcase
        count += 1;
      end else begin
        send_cmd(8'($urandom));
        count += 1;
      end
    end
  endtask

  // Run limit.
  initial begin
    #3000000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The register defaults are reported before anything is written.
    send_cmd(CMD_FULL_CONFIG);
    wait_idle();

    // Directed part: extreme registers and a heartbeat on every sample.
    set_config(8'hFF, 16'hFFFF, 16'h0000, 16'd1);
    send_cmd(CMD_FULL_CONFIG);
    send_cmd(CMD_SET_GAIN);
    send_cmd(GAIN_MAX);
    send_cmd(CMD_SET_GAIN);
    send_cmd(GAIN_MAX + 8'd1);
    send_cmd(CMD_SET_MUX);
    send_cmd(CHAN_MAX);
    send_cmd(CMD_SET_MUX);
    send_cmd(CHAN_MAX + 8'd1);
    send_cmd(CMD_SET_VREF);
    send_cmd(8'hFF);
    send_cmd(8'h00);
    send_cmd(8'h00);
    send_cmd(8'hFF);
    send_sample(24'h7FFFFF);
    send_sample(24'h800000);
    send_sample(24'h000000);
    send_sample(24'hFFFFFF);
    send_sample(24'h000001);
    // A command code given as an argument is just an invalid argument.
    send_cmd(CMD_SET_GAIN);
    send_cmd(CMD_FULL_CONFIG);
    // A sample arriving while the parser waits leaves the parser untouched.
    send_cmd(CMD_SET_VREF);
    send_cmd(8'h5A);
    send_sample(24'h123456);
    send_cmd(8'hC3);
    send_cmd(CMD_SET_MUX);
    send_cmd(8'h00);
    wait_idle();

    // Random registers and a short heartbeat period.
    dc_bias = 24'($urandom);
    set_config(8'($urandom), 16'($urandom), 16'($urandom), 16'd7);
    send_random_traffic(65);
    wait_idle();

    // The other extremes, with neither side idling.
    sender_idles = 1'b0;
    receiver_stalls = 1'b0;
    dc_bias = 24'h7FF000;
    set_config(8'h00, 16'h0000, 16'hFFFF, 16'hFFFF);
    send_random_traffic(65);
    wait_idle();

    // Period lowered below the running count, while the receiver holds off
    // long enough for the block to back up into its input.
    sender_idles = 1'b1;
    receiver_stalls = 1'b1;
    dc_bias = 24'h800400;
    set_config(8'($urandom), 16'($urandom), 16'($urandom), 16'd3);
    hold_request = 1'b1;
    send_random_traffic(65);
    wait_idle();

    // A period of zero gives a heartbeat after every sample.
    dc_bias = 24'h000000;
    set_config(RST_ADC_RES, RST_SAMPLE_RATE, RST_VREF_HALF, 16'd0);
    send_random_traffic(65);
    wait_idle();

    dc_bias = 24'($urandom);
    set_config(8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom_range(1, 20)));
    send_random_traffic(65);
    wait_idle();

    if (mismatch_count == 0 && bytes_owed == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
